// ===== hdl/prq_pkg.sv =====
// shared types and constants of the priority ready queue scheduler
package prq_pkg;

  localparam int PRIO_LEVELS_DEF = 32;
  localparam int ENTRY_COUNT_DEF = 16;

  localparam int ENTRY_ID_W = 4;
  localparam int PRIO_W     = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_DUP_INSERT = 2'd1,
    ST_NOT_QUEUED = 2'd2
  } status_t;

  typedef struct packed {
    op_t                   operation;
    logic [ENTRY_ID_W-1:0] entry_id;
    logic [PRIO_W-1:0]     priority_req;
  } prq_in_t;

  typedef struct packed {
    status_t               status;
    logic                  any_ready;
    logic [ENTRY_ID_W-1:0] top_entry;
    logic [PRIO_W-1:0]     top_priority;
  } prq_out_t;

  typedef struct packed {
    logic                  any_ready;
    logic [ENTRY_ID_W-1:0] top_entry;
    logic [PRIO_W-1:0]     top_priority;
  } prq_top_t;

endpackage

// ===== hdl/prq_entries.sv =====
// entry cells: queued flags, levels, age matrix and per-level head flags
module prq_entries import prq_pkg::*; #(
  parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
  localparam int LW = $clog2(PRIO_LEVELS),
  localparam int EW = $clog2(ENTRY_COUNT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  prq_in_t                item,
  output status_t                status,
  output logic [ENTRY_COUNT-1:0] head_nxt,
  output logic [LW-1:0]          level_nxt [ENTRY_COUNT]
);

  logic [ENTRY_COUNT-1:0] queued_r;
  logic [ENTRY_COUNT-1:0] queued_nxt;
  logic [LW-1:0]          level_r [ENTRY_COUNT];
  // older_r[i][j]: entry j went on the queue before entry i
  logic [ENTRY_COUNT-1:0] older_r [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] older_nxt [ENTRY_COUNT];

  logic [EW-1:0] idx;
  logic [LW-1:0] lvl;
  logic          in_range;
  logic          is_queued;
  logic          do_ins;
  logic          do_rem;

  always_comb begin
    idx       = EW'(item.entry_id);
    in_range  = (int'(item.entry_id) < ENTRY_COUNT);
    lvl       = (int'(item.priority_req) >= PRIO_LEVELS) ? LW'(PRIO_LEVELS - 1)
                                                        : LW'(item.priority_req);
    is_queued = in_range && queued_r[idx];

    if (item.operation == OP_INSERT) begin
      status = is_queued ? ST_DUP_INSERT : ST_DONE;
    end else begin
      status = is_queued ? ST_DONE : ST_NOT_QUEUED;
    end

    do_ins = step && (item.operation == OP_INSERT) && in_range && !is_queued;
    do_rem = step && (item.operation == OP_REMOVE) && is_queued;
  end

  // next state of every cell
  always_comb begin
    queued_nxt = queued_r;
    if (do_ins) begin
      queued_nxt[idx] = 1'b1;
    end
    if (do_rem) begin
      queued_nxt[idx] = 1'b0;
    end
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      level_nxt[i] = (do_ins && idx == EW'(i)) ? lvl : level_r[i];
      older_nxt[i] = older_r[i];
      if (do_ins) begin
        if (idx == EW'(i)) begin
          older_nxt[i] = queued_r;
        end else begin
          older_nxt[i][idx] = 1'b0;
        end
      end
    end
  end

  // a queued entry is head of its level when no queued entry there is older
  always_comb begin
    logic [ENTRY_COUNT-1:0] same_lvl;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      for (int j = 0; j < ENTRY_COUNT; j++) begin
        same_lvl[j] = (level_nxt[j] == level_nxt[i]);
      end
      head_nxt[i] = queued_nxt[i] && !(|(older_nxt[i] & queued_nxt & same_lvl));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
    end else if (step) begin
      queued_r <= queued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      level_r <= level_nxt;
      older_r <= older_nxt;
    end
  end

endmodule

// ===== hdl/prq_select.sv =====
// ready bitmap over the level heads and priority encode of the top level
module prq_select import prq_pkg::*; #(
  parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
  localparam int LW = $clog2(PRIO_LEVELS),
  localparam int EW = $clog2(ENTRY_COUNT)
) (
  input  logic [ENTRY_COUNT-1:0] head,
  input  logic [LW-1:0]          level [ENTRY_COUNT],
  output prq_top_t               top
);

  logic [PRIO_LEVELS-1:0] ready_levels;
  logic [LW-1:0]          top_lvl;
  logic [EW-1:0]          top_idx;
  logic                   found;

  always_comb begin
    ready_levels = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (head[i]) begin
        ready_levels[level[i]] = 1'b1;
      end
    end

    // highest set bit wins
    top_lvl = '0;
    found   = 1'b0;
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      if (ready_levels[l]) begin
        top_lvl = LW'(l);
        found   = 1'b1;
      end
    end

    // one head per level, so an or over the matches picks it
    top_idx = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (head[i] && level[i] == top_lvl) begin
        top_idx = top_idx | EW'(i);
      end
    end

    top.any_ready    = found;
    top.top_entry    = found ? ENTRY_ID_W'(top_idx) : '0;
    top.top_priority = found ? PRIO_W'(top_lvl) : '0;
  end

endmodule

// ===== hdl/priority_ready_queue_scheduler.sv =====
// top level of the priority ready queue scheduler
//
//   channel  ports                           word       direction
//   input    in_valid  in_stall  in_word     prq_in_t   into the block
//   result   out_valid out_stall out_word    prq_out_t  out of the block
//
// one word per cycle sustained while out_stall is low; the input register feeds the entry
// cells, the ready bitmap and the priority encoder, whose result is registered in the
// output register, which drives out_valid
// reset clears the queued flags, so every level starts empty
// a stalled result holds the output register; the input register still takes a
// word while it is empty, and in_stall rises only when both registers are full
//
// the queues are kept as a row of entry cells, each with a queued flag, a level
// and an age row telling which queued entries went in before it; the head of a
// level is its oldest queued entry, which gives the same fifo order as linked
// lists without any indexed read chains
module priority_ready_queue_scheduler import prq_pkg::*; #(
  parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  prq_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output prq_out_t out_word
);

  localparam int LW = $clog2(PRIO_LEVELS);

  // input register
  logic    in_v_r;
  prq_in_t in_item_r;

  // output register
  logic     out_v_r;
  prq_out_t out_word_r;
  prq_out_t out_word_nxt;

  logic out_free;
  logic adv;

  status_t                status;
  logic [ENTRY_COUNT-1:0] head_nxt;
  logic [LW-1:0]          level_nxt [ENTRY_COUNT];
  prq_top_t               top;

  // the output register frees up when empty or being drained this cycle
  assign out_free  = !out_v_r || !out_stall;
  assign adv       = in_v_r && out_free;
  assign in_stall  = in_v_r && !out_free;
  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

  prq_entries #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_entries (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (in_item_r),
    .status    (status),
    .head_nxt  (head_nxt),
    .level_nxt (level_nxt)
  );

  // top is taken from the state after this word's update
  prq_select #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_select (
    .head  (head_nxt),
    .level (level_nxt),
    .top   (top)
  );

  always_comb begin
    out_word_nxt.status       = status;
    out_word_nxt.any_ready    = top.any_ready;
    out_word_nxt.top_entry    = top.top_entry;
    out_word_nxt.top_priority = top.top_priority;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (out_free) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_word;
    end
    if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  // nothing ready means the top fields read zero
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_word_r.any_ready |->
      out_word_r.top_entry == '0 && out_word_r.top_priority == '0)
    else $error("top fields not zero while nothing is ready");

  // a completed insert of a real entry leaves something ready
  a_insert_ready: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_item_r.operation == OP_INSERT && status == ST_DONE &&
      int'(in_item_r.entry_id) < ENTRY_COUNT |=> out_word_r.any_ready)
    else $error("insert done but no entry ready");

  // error codes only go with their own operation
  a_status_op: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (status == ST_DUP_INSERT || status == ST_NOT_QUEUED) |->
      (status == ST_DUP_INSERT && in_item_r.operation == OP_INSERT) ||
      (status == ST_NOT_QUEUED && in_item_r.operation == OP_REMOVE))
    else $error("status code does not match operation");

  // a result only leaves the output register when it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_word_r))
    else $error("stalled result lost or changed");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the priority ready queue scheduler: directed, back-pressure and random traffic
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int NUM_LEVELS  = PRIO_LEVELS_DEF;
  localparam int NUM_ENTRIES = ENTRY_COUNT_DEF;
  // a result is offered from the output register after accept; quiet cycles follow the drain
  localparam int DRAIN_SLACK = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 60;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  prq_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  prq_out_t out_word;

  priority_ready_queue_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the handshake hangs
  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // scheduler shadow state
  // each entry carries a queued flag, its level and an insertion stamp; the head
  // of a level is its queued entry with the smallest stamp, which is the same
  // fifo order as the age rows of the entry cells inside the block
  // ---------------------------------------------------------------------------
  logic              ent_queued [NUM_ENTRIES];
  logic [PRIO_W-1:0] ent_level  [NUM_ENTRIES];
  int unsigned       ent_stamp  [NUM_ENTRIES];
  int unsigned       stamp_next = 0;
  prq_top_t          shadow_top = '0;
  prq_out_t          pending_reports [$];

  // run statistics
  int errors        = 0;
  int words_sent    = 0;
  int n_insert      = 0;
  int n_remove      = 0;
  int n_dup_insert  = 0;
  int n_not_queued  = 0;
  int queued_now    = 0;
  int max_queued    = 0;
  int in_stall_hits = 0;

  // idle controls shared by the tests, the sender and the receiver
  int gap_pct      = 0;
  int stall_pct    = 0;
  bit hold_request = 1'b0;
  int hold_left    = 0;

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ent_queued[i] = 1'b0;
      ent_level[i]  = '0;
      ent_stamp[i]  = 0;
    end
  end

  // applies one word to the shadow state and returns the report the block owes
  function automatic prq_out_t schedule_word(prq_in_t w);
    prq_out_t rpt;
    int       ent;
    int       lvl;
    int       best;
    ent = int'(w.entry_id);
    lvl = int'(w.priority_req);
    // levels past the top are folded onto the top level
    if (lvl >= NUM_LEVELS) lvl = NUM_LEVELS - 1;
    rpt = '0;
    rpt.status = ST_DONE;
    if (w.operation == OP_INSERT) begin
      n_insert++;
      // out-of-range entries on insert are silently ignored
      if (ent < NUM_ENTRIES) begin
        if (ent_queued[ent]) begin
          rpt.status = ST_DUP_INSERT;
          n_dup_insert++;
        end else begin
          ent_queued[ent] = 1'b1;
          ent_level[ent]  = PRIO_W'(lvl);
          ent_stamp[ent]  = stamp_next;
          stamp_next++;
          queued_now++;
          if (queued_now > max_queued) max_queued = queued_now;
        end
      end
    end else begin
      n_remove++;
      if (ent < NUM_ENTRIES && ent_queued[ent]) begin
        ent_queued[ent] = 1'b0;
        queued_now--;
      end else begin
        rpt.status = ST_NOT_QUEUED;
        n_not_queued++;
      end
    end

    // priority encode: highest level holding anything, oldest entry there
    best = -1;
    for (int l = NUM_LEVELS - 1; l >= 0 && best < 0; l--) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (ent_queued[i] && int'(ent_level[i]) == l &&
            (best < 0 || ent_stamp[i] < ent_stamp[best])) best = i;
      end
    end
    if (best >= 0) begin
      rpt.any_ready    = 1'b1;
      rpt.top_entry    = ENTRY_ID_W'(best);
      rpt.top_priority = ent_level[best];
    end
    shadow_top = {rpt.any_ready, rpt.top_entry, rpt.top_priority};
    return rpt;
  endfunction

  // idle lengths for sender gaps and stall runs: now and then a long stretch
  function automatic int idle_len();
    return ($urandom_range(9) == 0) ? int'($urandom_range(30, 8)) : int'($urandom_range(2, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one word, holds it steady through in_stall, then maybe idles
  // in_valid stays high between back-to-back words, so it is never dropped and
  // raised in the same step
  // ---------------------------------------------------------------------------
  task automatic send_word(input op_t op, input int ent, input int prio);
    prq_in_t w;
    w.operation    = op;
    w.entry_id     = ENTRY_ID_W'(ent);
    w.priority_req = PRIO_W'(prio);
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
      if (in_stall) in_stall_hits++;
    end while (in_stall);
    // word taken at this edge
    pending_reports.push_back(schedule_word(w));
    words_sent++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall runs, plus a long hold-off on request that is
  // counted down here; exactly one assignment to out_stall per edge
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b1;
        run_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        run_left = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic field_mismatch(input string name, input logic [7:0] want,
                                input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    prq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_word);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_word.status !== want.status)
          field_mismatch("status", 8'(want.status), 8'(out_word.status));
        if (out_word.any_ready !== want.any_ready)
          field_mismatch("any_ready", 8'(want.any_ready), 8'(out_word.any_ready));
        if (out_word.top_entry !== want.top_entry)
          field_mismatch("top_entry", 8'(want.top_entry), 8'(out_word.top_entry));
        if (out_word.top_priority !== want.top_priority)
          field_mismatch("top_priority", 8'(want.top_priority), 8'(out_word.top_priority));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked sequence: extremes, duplicates, idle removes, head/middle/tail
  // unlinks and a level emptied by removing its only entry
  task automatic test_directed_cases();
    gap_pct   = 20;
    stall_pct = 20;
    send_word(OP_REMOVE, 0, 0);       // remove on an empty scheduler
    send_word(OP_INSERT, 0, 0);       // lowest entry at the lowest level
    send_word(OP_INSERT, 0, 5);       // already queued
    send_word(OP_INSERT, 15, 31);     // highest entry at the highest level
    send_word(OP_INSERT, 5, 31);
    send_word(OP_INSERT, 9, 31);      // level 31 now holds 15, 5, 9
    send_word(OP_REMOVE, 5, 31);      // unlink from the middle
    send_word(OP_REMOVE, 15, 0);      // head goes, 9 takes over
    send_word(OP_INSERT, 3, 31);
    send_word(OP_REMOVE, 3, 12);      // unlink the tail
    send_word(OP_REMOVE, 9, 31);      // last one on level 31, bit clears
    send_word(OP_REMOVE, 9, 31);      // no longer queued
    send_word(OP_INSERT, 10, 16);
    send_word(OP_INSERT, 6, 16);
    send_word(OP_INSERT, 12, 16);
    send_word(OP_REMOVE, 10, 0);      // head of 16 leaves, 6 is next
    send_word(OP_REMOVE, 12, 16);
    send_word(OP_REMOVE, 6, 16);      // level 16 empties, back to level 0
    send_word(OP_INSERT, 10, 1);      // higher level than the waiting entry 0
    send_word(OP_REMOVE, 0, 31);      // remove ignores its level field
    send_word(OP_REMOVE, 10, 1);      // scheduler empty again
    send_word(OP_REMOVE, 15, 31);
  endtask

  // receiver holds off for a long stretch while words keep coming, so both
  // internal registers fill and in_stall has to rise
  task automatic test_backpressure();
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i < NUM_ENTRIES) send_word(OP_INSERT, i, $urandom_range(NUM_LEVELS - 1));
      else send_word(OP_REMOVE, $urandom_range(NUM_ENTRIES - 1), 0);
    end
  endtask

  // mostly meaningful operations with random content, a share of duplicate
  // inserts and idle removes as noise; levels lean on a few hot values so that
  // queues get deep and fifo order matters
  task automatic test_random_traffic();
    int    gap_mix   [5] = '{0, 20, 60, 10, 40};
    int    stall_mix [5] = '{0, 20, 10, 60, 40};
    int    pick;
    int    ent;
    int    prio;
    op_t   op;
    for (int phase = 0; phase < 5; phase++) begin
      gap_pct   = gap_mix[phase];
      stall_pct = stall_mix[phase];
      for (int n = 0; n < 285; n++) begin
        pick = $urandom_range(99);
        prio = ($urandom_range(1) == 1) ? int'($urandom_range(NUM_LEVELS - 1))
                                        : int'($urandom_range(3)) * 10 + 1;
        if (pick < 15 && shadow_top.any_ready) begin
          // pull the current head so the next one gets promoted
          op  = OP_REMOVE;
          ent = int'(shadow_top.top_entry);
        end else begin
          ent = $urandom_range(NUM_ENTRIES - 1);
          if (ent_queued[ent]) op = (pick < 93) ? OP_REMOVE : OP_INSERT;
          else op = (pick < 93) ? OP_INSERT : OP_REMOVE;
        end
        send_word(op, ent, prio);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin : run_control
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    gap_pct = 0;
    // drain, then a quiet stretch to catch stray results
    waited = 0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
      errors += pending_reports.size();
    end

    $display("run covered %0d words: %0d inserts (%0d already queued), %0d removes (%0d idle)",
             words_sent, n_insert, n_dup_insert, n_remove, n_not_queued);
    $display("up to %0d entries queued at once, sender held off on %0d edges, %0d errors",
             max_queued, in_stall_hits, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/prq_pkg.sv
hdl/prq_entries.sv
hdl/prq_select.sv
hdl/priority_ready_queue_scheduler.sv
tb/sv/tb.sv
